### rtl/vector_angle_degrees_defines.svh
// Assertion macros for the vector angle block.
`ifndef VECTOR_ANGLE_DEGREES_DEFINES_SVH
`define VECTOR_ANGLE_DEGREES_DEFINES_SVH

// Implication checked every clock, masked while reset is high.
`define VAD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check in the cycle after the antecedent.
`define VAD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/vad_pkg.sv
// Shared types, widths and the CORDIC angle table for the vector angle block.
`default_nettype none
package vad_pkg;

   localparam int COMPONENT_BITS_DEF = 32;
   localparam int PS_BITS    = 31;   // prescaled component, magnitude below 2^30
   localparam int HALF_BITS  = 30;
   localparam int PROD_BITS  = 62;
   localparam int DOT_BITS   = 63;
   localparam int CROSS_BITS = 62;
   localparam int CMAG_BITS  = 61;
   localparam int CLO_BITS   = 31;
   localparam int CHI_BITS   = 30;
   localparam int SQ_BITS    = 122;
   localparam int SUM_BITS   = 124;
   localparam int ROOT_BITS  = 62;
   localparam int MAG_BITS   = 63;
   localparam int POS_BITS   = 6;
   localparam int NORM_TOP   = 59;
   localparam int CORD_BITS  = 64;
   localparam int ANG_BITS   = 32;
   localparam int ANG_FRAC   = 24;
   localparam int CORDIC_STEPS = 24;
   localparam int OUT_BITS   = 24;
   localparam int QUEUE_DEPTH = 4;
   localparam logic [OUT_BITS-1:0] OUT_MAX  = 24'd11796480;
   localparam logic [OUT_BITS-1:0] OUT_RIGHT = 24'd5898240;

   typedef struct packed {
      logic signed [PS_BITS-1:0] ax;
      logic signed [PS_BITS-1:0] ay;
      logic signed [PS_BITS-1:0] az;
      logic signed [PS_BITS-1:0] bx;
      logic signed [PS_BITS-1:0] by;
      logic signed [PS_BITS-1:0] bz;
      logic                      deg;
   } vad_item_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] angle;
      logic                deg;
   } vad_result_type;

   // Stage control carried down the back pipeline.
   typedef struct packed {
      logic deg;
      logic dneg;
   } vad_flags_type;

   function automatic logic signed [ANG_BITS-1:0] atan_deg(input int unsigned i);
      logic signed [ANG_BITS-1:0] r;
      case (i)
         0:  r = 32'sd754974720;
         1:  r = 32'sd445687602;
         2:  r = 32'sd235489088;
         3:  r = 32'sd119537938;
         4:  r = 32'sd60000934;
         5:  r = 32'sd30029717;
         6:  r = 32'sd15018523;
         7:  r = 32'sd7509720;
         8:  r = 32'sd3754917;
         9:  r = 32'sd1877466;
         10: r = 32'sd938734;
         11: r = 32'sd469367;
         12: r = 32'sd234684;
         13: r = 32'sd117342;
         14: r = 32'sd58671;
         15: r = 32'sd29335;
         16: r = 32'sd14668;
         17: r = 32'sd7334;
         18: r = 32'sd3667;
         19: r = 32'sd1833;
         20: r = 32'sd917;
         21: r = 32'sd458;
         22: r = 32'sd229;
         23: r = 32'sd115;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/vad_fifo.sv
// Small first-word-fall-through queue.
`default_nettype none
module vad_fifo #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output logic                      full,
   input  wire logic [DATA_BITS-1:0] wdata,
   input  wire logic                 pop,
   output logic                      empty,
   output logic [DATA_BITS-1:0]      rdata
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end
endmodule
`default_nettype wire

### rtl/vad_front.sv
// Front end: sign/magnitude split, per-vector prescale and zero-vector detect.
`default_nettype none
module vad_front #(
   parameter int COMPONENT_BITS = 32
) (
   input  wire logic signed [COMPONENT_BITS-1:0] first_x,
   input  wire logic signed [COMPONENT_BITS-1:0] first_y,
   input  wire logic signed [COMPONENT_BITS-1:0] first_z,
   input  wire logic signed [COMPONENT_BITS-1:0] second_x,
   input  wire logic signed [COMPONENT_BITS-1:0] second_y,
   input  wire logic signed [COMPONENT_BITS-1:0] second_z,
   output vad_pkg::vad_item_type                 item
);
   import vad_pkg::*;

   localparam int CB = COMPONENT_BITS;
   localparam int LW = $clog2(CB + 1);

   logic [CB-1:0]      comp [6];
   logic [CB-1:0]      mag [6];
   logic               neg [6];
   logic [CB-1:0]      top [2];
   logic [LW-1:0]      len [2];
   logic [LW-1:0]      shamt [2];
   logic [CB+HALF_BITS-1:0] wide [6];
   logic signed [PS_BITS-1:0] ps [6];

   assign comp[0] = first_x;
   assign comp[1] = first_y;
   assign comp[2] = first_z;
   assign comp[3] = second_x;
   assign comp[4] = second_y;
   assign comp[5] = second_z;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         neg[k] = comp[k][CB-1];
         mag[k] = neg[k] ? (~comp[k] + 1'b1) : comp[k];
      end
      for (int v = 0; v < 2; v++) begin
         // bit length of the OR equals that of the largest magnitude
         top[v] = mag[3*v] | mag[3*v+1] | mag[3*v+2];
         len[v] = '0;
         for (int i = 0; i < CB; i++) begin
            if (top[v][i]) len[v] = LW'(i + 1);
         end
         shamt[v] = (len[v] > LW'(HALF_BITS)) ? len[v] - LW'(HALF_BITS) : '0;
      end
      for (int k = 0; k < 6; k++) begin
         wide[k] = {{HALF_BITS{1'b0}}, mag[k]} >> shamt[k/3];
         ps[k]   = neg[k] ? -$signed({1'b0, wide[k][HALF_BITS-1:0]})
                          : $signed({1'b0, wide[k][HALF_BITS-1:0]});
      end
      item.ax  = ps[0];
      item.ay  = ps[1];
      item.az  = ps[2];
      item.bx  = ps[3];
      item.by  = ps[4];
      item.bz  = ps[5];
      item.deg = (top[0] == '0) | (top[1] == '0);
   end
endmodule
`default_nettype wire

### rtl/vad_back.sv
// Back end: products, cross magnitude square root, normalize, CORDIC, final angle.
`default_nettype none
module vad_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_pop,
   input  wire vad_pkg::vad_item_type in_item,
   output logic                       out_push,
   input  wire logic                  out_full,
   output vad_pkg::vad_result_type    out_result
);
   import vad_pkg::*;

   localparam int SQRT_STAGES = ROOT_BITS;

   logic en;
   assign en     = ~out_full;
   assign in_pop = en & in_valid;

   // stage 1: nine products
   logic                        v1_ff;
   logic signed [PROD_BITS-1:0] p_ff [9];
   logic                        deg1_ff;
   // stage 2: dot and cross magnitudes
   logic                        v2_ff;
   logic [MAG_BITS-1:0]         x2_ff;
   logic [CMAG_BITS-1:0]        cm2_ff [3];
   vad_flags_type               f2_ff;
   // stage 3: partial squares
   logic                        v3_ff;
   logic [MAG_BITS-1:0]         x3_ff;
   logic [2*CHI_BITS-1:0]       hh3_ff [3];
   logic [CHI_BITS+CLO_BITS-1:0] hl3_ff [3];
   logic [2*CLO_BITS-1:0]       ll3_ff [3];
   vad_flags_type               f3_ff;
   // stage 4: full squares
   logic                        v4_ff;
   logic [MAG_BITS-1:0]         x4_ff;
   logic [SQ_BITS-1:0]          sq4_ff [3];
   vad_flags_type               f4_ff;
   // square root chain, index 0 holds the radicand
   logic                        sv_ff  [SQRT_STAGES+1];
   logic [SUM_BITS-1:0]         rem_ff [SQRT_STAGES+1];
   logic [ROOT_BITS-1:0]        root_ff[SQRT_STAGES+1];
   logic [MAG_BITS-1:0]         sx_ff  [SQRT_STAGES+1];
   vad_flags_type               sf_ff  [SQRT_STAGES+1];
   // normalize
   logic                        vn1_ff;
   logic [MAG_BITS-1:0]         xn1_ff, yn1_ff;
   logic [POS_BITS-1:0]         pos_ff;
   logic                        dz1_ff, yz1_ff;
   vad_flags_type               fn1_ff;
   // CORDIC chain, index 0 holds the normalized pair
   logic                        cv_ff [CORDIC_STEPS+1];
   logic signed [CORD_BITS-1:0] cx_ff [CORDIC_STEPS+1];
   logic signed [CORD_BITS-1:0] cy_ff [CORDIC_STEPS+1];
   logic signed [ANG_BITS-1:0]  cz_ff [CORDIC_STEPS+1];
   logic                        cdz_ff[CORDIC_STEPS+1];
   logic                        cyz_ff[CORDIC_STEPS+1];
   vad_flags_type               cf_ff [CORDIC_STEPS+1];

   // stage 1
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= PROD_BITS'(in_item.ax * in_item.bx);
         p_ff[1] <= PROD_BITS'(in_item.ay * in_item.by);
         p_ff[2] <= PROD_BITS'(in_item.az * in_item.bz);
         p_ff[3] <= PROD_BITS'(in_item.ay * in_item.bz);
         p_ff[4] <= PROD_BITS'(in_item.az * in_item.by);
         p_ff[5] <= PROD_BITS'(in_item.az * in_item.bx);
         p_ff[6] <= PROD_BITS'(in_item.ax * in_item.bz);
         p_ff[7] <= PROD_BITS'(in_item.ax * in_item.by);
         p_ff[8] <= PROD_BITS'(in_item.ay * in_item.bx);
         deg1_ff <= in_item.deg;
      end
   end

   // stage 2
   logic signed [DOT_BITS-1:0]   d_in;
   logic signed [CROSS_BITS-1:0] c_in [3];
   always_comb begin
      d_in = DOT_BITS'(p_ff[0]) + DOT_BITS'(p_ff[1]) + DOT_BITS'(p_ff[2]);
      for (int k = 0; k < 3; k++) begin
         c_in[k] = CROSS_BITS'(p_ff[3+2*k]) - CROSS_BITS'(p_ff[4+2*k]);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         x2_ff <= d_in[DOT_BITS-1] ? MAG_BITS'(-d_in) : MAG_BITS'(d_in);
         for (int k = 0; k < 3; k++) begin
            cm2_ff[k] <= c_in[k][CROSS_BITS-1] ? CMAG_BITS'(-c_in[k]) : CMAG_BITS'(c_in[k]);
         end
         f2_ff.deg  <= deg1_ff;
         f2_ff.dneg <= d_in[DOT_BITS-1];
      end
   end

   // stage 3: |c| split as hi*2^31 + lo
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            hh3_ff[k] <= cm2_ff[k][CMAG_BITS-1:CLO_BITS] * cm2_ff[k][CMAG_BITS-1:CLO_BITS];
            hl3_ff[k] <= cm2_ff[k][CMAG_BITS-1:CLO_BITS] * cm2_ff[k][CLO_BITS-1:0];
            ll3_ff[k] <= cm2_ff[k][CLO_BITS-1:0] * cm2_ff[k][CLO_BITS-1:0];
         end
         x3_ff <= x2_ff;
         f3_ff <= f2_ff;
      end
   end

   // stage 4
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            sq4_ff[k] <= (SQ_BITS'(hh3_ff[k]) << (2*CLO_BITS))
                       + (SQ_BITS'(hl3_ff[k]) << (CLO_BITS+1))
                       + SQ_BITS'(ll3_ff[k]);
         end
         x4_ff <= x3_ff;
         f4_ff <= f3_ff;
      end
   end

   // stage 5: sum of squares enters the root chain
   always_ff @(posedge clock) begin
      if (reset) sv_ff[0] <= 1'b0;
      else if (en) sv_ff[0] <= v4_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= SUM_BITS'(sq4_ff[0]) + SUM_BITS'(sq4_ff[1]) + SUM_BITS'(sq4_ff[2]);
         root_ff[0] <= '0;
         sx_ff[0]   <= x4_ff;
         sf_ff[0]   <= f4_ff;
      end
   end

   // one root bit per stage, most significant first
   for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
      localparam int B = ROOT_BITS - 1 - j;
      logic [SUM_BITS:0] trial;
      logic              take;
      assign trial = ((SUM_BITS+1)'(root_ff[j]) << (B + 1)) | ((SUM_BITS+1)'(1) << (2*B));
      assign take  = ({1'b0, rem_ff[j]} >= trial);
      always_ff @(posedge clock) begin
         if (reset) sv_ff[j+1] <= 1'b0;
         else if (en) sv_ff[j+1] <= sv_ff[j];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1]  <= take ? rem_ff[j] - trial[SUM_BITS-1:0] : rem_ff[j];
            root_ff[j+1] <= take ? (root_ff[j] | (ROOT_BITS'(1) << B)) : root_ff[j];
            sx_ff[j+1]   <= sx_ff[j];
            sf_ff[j+1]   <= sf_ff[j];
         end
      end
   end

   // normalize step 1: leading one of max(X, Y)
   logic [MAG_BITS-1:0] y_root, m_in;
   logic [POS_BITS-1:0] pos_in;
   always_comb begin
      y_root = MAG_BITS'(root_ff[SQRT_STAGES]);
      m_in   = (sx_ff[SQRT_STAGES] > y_root) ? sx_ff[SQRT_STAGES] : y_root;
      pos_in = '0;
      for (int i = 0; i < MAG_BITS; i++) begin
         if (m_in[i]) pos_in = POS_BITS'(i);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) vn1_ff <= 1'b0;
      else if (en) vn1_ff <= sv_ff[SQRT_STAGES];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         xn1_ff <= sx_ff[SQRT_STAGES];
         yn1_ff <= y_root;
         pos_ff <= pos_in;
         dz1_ff <= (sx_ff[SQRT_STAGES] == '0);
         yz1_ff <= (y_root == '0);
         fn1_ff <= sf_ff[SQRT_STAGES];
      end
   end

   // normalize step 2: bring the leading one to bit 59
   logic [CORD_BITS-1:0] xs_in, ys_in;
   always_comb begin
      if (pos_ff >= POS_BITS'(NORM_TOP)) begin
         xs_in = CORD_BITS'(xn1_ff) >> (pos_ff - POS_BITS'(NORM_TOP));
         ys_in = CORD_BITS'(yn1_ff) >> (pos_ff - POS_BITS'(NORM_TOP));
      end else begin
         xs_in = CORD_BITS'(xn1_ff) << (POS_BITS'(NORM_TOP) - pos_ff);
         ys_in = CORD_BITS'(yn1_ff) << (POS_BITS'(NORM_TOP) - pos_ff);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) cv_ff[0] <= 1'b0;
      else if (en) cv_ff[0] <= vn1_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0]  <= $signed(xs_in);
         cy_ff[0]  <= $signed(ys_in);
         cz_ff[0]  <= '0;
         cdz_ff[0] <= dz1_ff;
         cyz_ff[0] <= yz1_ff;
         cf_ff[0]  <= fn1_ff;
      end
   end

   // CORDIC vectoring, arithmetic shifts round toward minus infinity
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [CORD_BITS-1:0] dx, dy;
      assign dx = cy_ff[i] >>> i;
      assign dy = cx_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (reset) cv_ff[i+1] <= 1'b0;
         else if (en) cv_ff[i+1] <= cv_ff[i];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (!cy_ff[i][CORD_BITS-1]) begin
               cx_ff[i+1] <= cx_ff[i] + dx;
               cy_ff[i+1] <= cy_ff[i] - dy;
               cz_ff[i+1] <= cz_ff[i] + atan_deg(i);
            end else begin
               cx_ff[i+1] <= cx_ff[i] - dx;
               cy_ff[i+1] <= cy_ff[i] + dy;
               cz_ff[i+1] <= cz_ff[i] - atan_deg(i);
            end
            cdz_ff[i+1] <= cdz_ff[i];
            cyz_ff[i+1] <= cyz_ff[i];
            cf_ff[i+1]  <= cf_ff[i];
         end
      end
   end

   // final angle: clamp, mirror for negative dot, round, cap
   localparam logic signed [ANG_BITS-1:0] Z90  = 32'sd90 <<< ANG_FRAC;
   localparam logic signed [ANG_BITS-1:0] Z180 = 32'sd180 <<< ANG_FRAC;
   logic signed [ANG_BITS-1:0] zc, zm;
   logic [ANG_BITS-1:0]        zr;
   logic [OUT_BITS-1:0]        ang;
   vad_flags_type              ff;
   assign ff = cf_ff[CORDIC_STEPS];
   always_comb begin
      zc = cz_ff[CORDIC_STEPS];
      if (zc < 0) zc = '0;
      if (zc > Z90) zc = Z90;
      zm = ff.dneg ? Z180 - zc : zc;
      zr = ($unsigned(zm) + ANG_BITS'(128)) >> 8;
      ang = (zr > ANG_BITS'(OUT_MAX)) ? OUT_MAX : zr[OUT_BITS-1:0];
      out_result.deg = ff.deg;
      if (ff.deg) begin
         out_result.angle = '0;
      end else if (cyz_ff[CORDIC_STEPS]) begin
         out_result.angle = ff.dneg ? OUT_MAX : '0;
      end else if (cdz_ff[CORDIC_STEPS]) begin
         out_result.angle = OUT_RIGHT;
      end else begin
         out_result.angle = ang;
      end
   end
   assign out_push = en & cv_ff[CORDIC_STEPS];
endmodule
`default_nettype wire

### rtl/vector_angle_degrees.sv
// Angle between two 3D vectors: accepts one pair per cycle while req_full is
// low. After its word is accepted, a result passes the input queue, products,
// 62-stage square root, normalize, 24 CORDIC stages and the output queue. The
// root chain sets the depth. Sustained rate one word per cycle while rsp_pop keeps up.
// Synchronous active-high reset empties both queues and all stage valid bits.
`default_nettype none
`include "vector_angle_degrees_defines.svh"
module vector_angle_degrees #(
   parameter int COMPONENT_BITS = vad_pkg::COMPONENT_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_push,
   output logic                                       req_full,
   input  wire logic signed [COMPONENT_BITS-1:0]      req_first_x,
   input  wire logic signed [COMPONENT_BITS-1:0]      req_first_y,
   input  wire logic signed [COMPONENT_BITS-1:0]      req_first_z,
   input  wire logic signed [COMPONENT_BITS-1:0]      req_second_x,
   input  wire logic signed [COMPONENT_BITS-1:0]      req_second_y,
   input  wire logic signed [COMPONENT_BITS-1:0]      req_second_z,
   output logic                                       rsp_empty,
   input  wire logic                                  rsp_pop,
   output logic [vad_pkg::OUT_BITS-1:0]               rsp_angle_deg,
   output logic                                       rsp_degenerate
);
   import vad_pkg::*;

   vad_item_type   front_item, mid_item;
   vad_result_type back_result, out_word;
   logic mid_empty, mid_full, mid_pop, out_push, out_full;

   vad_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
      .first_x (req_first_x),
      .first_y (req_first_y),
      .first_z (req_first_z),
      .second_x(req_second_x),
      .second_y(req_second_y),
      .second_z(req_second_z),
      .item    (front_item)
   );

   vad_fifo #(.DATA_BITS($bits(vad_item_type)), .DEPTH(QUEUE_DEPTH)) u_mid_q (
      .clock(clock),
      .reset(reset),
      .push (req_push),
      .full (mid_full),
      .wdata(front_item),
      .pop  (mid_pop),
      .empty(mid_empty),
      .rdata(mid_item)
   );
   assign req_full = mid_full;

   vad_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (~mid_empty),
      .in_pop    (mid_pop),
      .in_item   (mid_item),
      .out_push  (out_push),
      .out_full  (out_full),
      .out_result(back_result)
   );

   vad_fifo #(.DATA_BITS($bits(vad_result_type)), .DEPTH(QUEUE_DEPTH)) u_out_q (
      .clock(clock),
      .reset(reset),
      .push (out_push),
      .full (out_full),
      .wdata(back_result),
      .pop  (rsp_pop),
      .empty(rsp_empty),
      .rdata(out_word)
   );
   assign rsp_angle_deg  = out_word.angle;
   assign rsp_degenerate = out_word.deg;

   `VAD_ASSERT_IMP(a_deg_zero, !rsp_empty && rsp_degenerate, rsp_angle_deg == '0, "degen angle")
   `VAD_ASSERT_IMP(a_angle_max, !rsp_empty, rsp_angle_deg <= OUT_MAX, "angle above 180")
   `VAD_ASSERT_NEXT(a_mid_fill, req_push && !req_full, !mid_empty, "input word lost")
   `VAD_ASSERT_IMP(a_no_drop, out_full, !out_push, "push into full output queue")
endmodule
`default_nettype wire

### bench/tb_vector_angle_degrees.sv
// Testbench for vector_angle_degrees: queued random and directed vector pairs, scoreboard check.
`default_nettype none
module tb_vector_angle_degrees;
   import vad_pkg::*;

   localparam int CB = COMPONENT_BITS_DEF;
   localparam int WATCH_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [CB-1:0] comp [6];
   } pair_word_type;

   typedef struct {
      logic [OUT_BITS-1:0] angle;
      logic                degen;
   } angle_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [CB-1:0] req_first_x = '0, req_first_y = '0, req_first_z = '0;
   logic signed [CB-1:0] req_second_x = '0, req_second_y = '0, req_second_z = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [OUT_BITS-1:0] rsp_angle_deg;
   logic rsp_degenerate;

   pair_word_type  pending_pairs [$];
   angle_word_type expected_angles [$];
   int  fail_count = 0;
   int  accepted_pairs = 0;
   int  hold_left = 0;
   bit  hold_done = 0;
   bit  pause_done = 0;
   bit  pausing = 0;
   int  idle_cycles = 0;

   vector_angle_degrees dut (
      .clock, .reset, .req_push, .req_full,
      .req_first_x, .req_first_y, .req_first_z,
      .req_second_x, .req_second_y, .req_second_z,
      .rsp_empty, .rsp_pop, .rsp_angle_deg, .rsp_degenerate
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Prescale one vector; returns 1 when all components are zero.
   function automatic bit prescale(input logic [CB-1:0] raw [3], output longint v [3]);
      logic [63:0] m [3];
      logic [63:0] top;
      int s;
      top = 0;
      for (int k = 0; k < 3; k++) begin
         m[k] = raw[k][CB-1] ? ((~{32'd0, raw[k]}) + 64'd1) & 64'hffff_ffff : {32'd0, raw[k]};
         if (m[k] > top) top = m[k];
      end
      s = 0;
      while (s < 63 && (top >> s) >= (64'd1 << 30)) s++;
      for (int k = 0; k < 3; k++)
         v[k] = raw[k][CB-1] ? -longint'(m[k] >> s) : longint'(m[k] >> s);
      return top == 0;
   endfunction

   function automatic angle_word_type angle_of_pair(input pair_word_type p);
      angle_word_type r;
      logic [CB-1:0] ra [3], rb [3];
      longint a [3], b [3], c [3], d, x, y, z, dx, dy;
      logic [127:0] sum, t2;
      logic [63:0] root, t, bx, by, m, ac;
      bit za, zb;
      for (int k = 0; k < 3; k++) begin
         ra[k] = p.comp[k];
         rb[k] = p.comp[k+3];
      end
      za = prescale(ra, a);
      zb = prescale(rb, b);
      r.angle = '0;
      r.degen = 1'b1;
      if (za || zb) return r;
      r.degen = 1'b0;
      d = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
      c[0] = a[1]*b[2] - a[2]*b[1];
      c[1] = a[2]*b[0] - a[0]*b[2];
      c[2] = a[0]*b[1] - a[1]*b[0];
      sum = 0;
      for (int k = 0; k < 3; k++) begin
         ac = c[k] < 0 ? 64'(-c[k]) : 64'(c[k]);
         sum += {64'd0, ac} * {64'd0, ac};
      end
      root = 0;
      for (int i = 62; i >= 0; i--) begin
         t = root | (64'd1 << i);
         t2 = {64'd0, t} * {64'd0, t};
         if (t2 <= sum) root = t;
      end
      if (root == 0) begin
         r.angle = d > 0 ? '0 : OUT_MAX;
         return r;
      end
      if (d == 0) begin
         r.angle = OUT_RIGHT;
         return r;
      end
      bx = d < 0 ? 64'(-d) : 64'(d);
      by = root;
      m = bx > by ? bx : by;
      while (m >= (64'd1 << 60)) begin bx >>= 1; by >>= 1; m >>= 1; end
      while (m < (64'd1 << 59)) begin bx <<= 1; by <<= 1; m <<= 1; end
      x = longint'(bx);
      y = longint'(by);
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;   // arithmetic shift floors negative values
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += longint'(atan_deg(i));
         end else begin
            x -= dx; y += dy; z -= longint'(atan_deg(i));
         end
      end
      if (z < 0) z = 0;
      if (z > (longint'(90) << ANG_FRAC)) z = longint'(90) << ANG_FRAC;
      if (d < 0) z = (longint'(180) << ANG_FRAC) - z;
      z = (z + 128) >>> 8;
      if (z > longint'(OUT_MAX)) z = longint'(OUT_MAX);
      r.angle = z[OUT_BITS-1:0];
      return r;
   endfunction

   function automatic pair_word_type make_pair(input logic [CB-1:0] ax, ay, az, bx, by, bz);
      pair_word_type p;
      p.comp[0] = ax; p.comp[1] = ay; p.comp[2] = az;
      p.comp[3] = bx; p.comp[4] = by; p.comp[5] = bz;
      return p;
   endfunction

   function automatic logic [CB-1:0] rand_comp(input int kind);
      logic signed [CB-1:0] v;
      case (kind)
         0: v = $urandom;
         1: v = $signed($urandom_range(0, 2000)) - 1000;
         2: v = $urandom_range(0, 1) ? 32'sh7fff_ffff - $urandom_range(0, 3)
                                     : 32'sh8000_0000 + $urandom_range(0, 3);
         default: v = $signed($urandom) >>> $urandom_range(0, 31);
      endcase
      return v;
   endfunction

   function automatic pair_word_type random_pair();
      pair_word_type p;
      logic signed [CB-1:0] k, ax, ay, az;
      int shape;
      shape = $urandom_range(0, 99);
      for (int i = 0; i < 6; i++) p.comp[i] = rand_comp($urandom_range(0, 3));
      if (shape < 10) begin
         // parallel or antiparallel: b = k * a
         ax = $signed($urandom_range(0, 60000)) - 30000;
         ay = $signed($urandom_range(0, 60000)) - 30000;
         az = $signed($urandom_range(0, 60000)) - 30000;
         k = $signed($urandom_range(0, 40)) - 20;
         p = make_pair(ax, ay, az, ax * k, ay * k, az * k);
      end else if (shape < 18) begin
         // perpendicular: b = a x e for a unit axis
         ax = rand_comp(1); ay = rand_comp(1); az = rand_comp(1);
         p = make_pair(ax, ay, az, 0, az, -ay);
      end else if (shape < 22) begin
         for (int i = 0; i < 3; i++) p.comp[i + 3 * $urandom_range(0, 1)] = '0;
      end
      return p;
   endfunction

   // Driver
   always @(posedge clock) begin
      bit idle;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            expected_angles.push_back(angle_of_pair(pending_pairs.pop_front()));
            accepted_pairs++;
         end
         if (!pause_done && accepted_pairs >= 1400) begin
            pausing = 1;
            pause_done = 1;
         end
         if (pausing && expected_angles.size() == 0) pausing = 0;
         if (accepted_pairs < 700) idle = ($urandom_range(0, 99) < 9);
         else if (accepted_pairs < 1300) idle = ($urandom_range(0, 99) < 55);
         else idle = 0;
         if (pending_pairs.size() > 0 && !idle && !pausing) begin
            req_push <= 1'b1;
            req_first_x <= pending_pairs[0].comp[0];
            req_first_y <= pending_pairs[0].comp[1];
            req_first_z <= pending_pairs[0].comp[2];
            req_second_x <= pending_pairs[0].comp[3];
            req_second_y <= pending_pairs[0].comp[4];
            req_second_z <= pending_pairs[0].comp[5];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      angle_word_type want;
      bit stall;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_angles.size() == 0) begin
               $error("result word with nothing expected");
               fail_count++;
            end else begin
               want = expected_angles.pop_front();
               if (rsp_angle_deg !== want.angle) begin
                  $error("angle_deg expected %0d actual %0d", want.angle, rsp_angle_deg);
                  fail_count++;
               end
               if (rsp_degenerate !== want.degen) begin
                  $error("degenerate expected %0d actual %0d", want.degen, rsp_degenerate);
                  fail_count++;
               end
            end
         end
         // long hold-off so the block fills and backs up its input
         if (!hold_done && accepted_pairs >= 500) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall = 1;
         end else if (accepted_pairs < 700) stall = ($urandom_range(0, 99) < 55);
         else if (accepted_pairs < 1300) stall = ($urandom_range(0, 99) < 9);
         else stall = 0;
         rsp_pop <= !stall;
      end
   end

   // Watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [CB-1:0] pmax, nmax;
      pmax = 32'h7fff_ffff;
      nmax = 32'h8000_0000;
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(0, 0, 0, 1, 2, 3));
      pending_pairs.push_back(make_pair(5, 6, 7, 0, 0, 0));
      pending_pairs.push_back(make_pair(pmax, pmax, pmax, pmax, pmax, pmax));
      pending_pairs.push_back(make_pair(nmax, nmax, nmax, nmax, nmax, nmax));
      pending_pairs.push_back(make_pair(pmax, pmax, pmax, nmax, nmax, nmax));
      pending_pairs.push_back(make_pair(nmax, 0, 0, 0, nmax, 0));
      pending_pairs.push_back(make_pair(pmax, 0, 0, 0, 0, pmax));
      pending_pairs.push_back(make_pair(1, 0, 0, 1, 0, 0));
      pending_pairs.push_back(make_pair(1, 0, 0, -1, 0, 0));
      pending_pairs.push_back(make_pair(1, 0, 0, 0, 1, 0));
      pending_pairs.push_back(make_pair(65536, 0, 0, 65536, 65536, 0));
      pending_pairs.push_back(make_pair(65536, 0, 0, -65536, 65536, 0));
      pending_pairs.push_back(make_pair(1, 1, 1, -1, -1, -1));
      pending_pairs.push_back(make_pair(pmax, 1, 0, pmax, 0, 1));
      pending_pairs.push_back(make_pair(nmax, pmax, 1, -1, 1, nmax));
      pending_pairs.push_back(make_pair(32'hffff_ffff, 0, 0, 1, 1, 0));
      pending_pairs.push_back(make_pair(3, 4, 0, 4, -3, 0));
      repeat (1900) pending_pairs.push_back(random_pair());
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (pending_pairs.size() != 0 || expected_angles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_angles.size() == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire
